@@ design/triangle_pixel_cover_interpolate_unit_macros.svh @@
// assertion macros shared by the checker of the triangle cover unit
`ifndef TRIANGLE_PIXEL_COVER_INTERPOLATE_UNIT_MACROS_SVH
`define TRIANGLE_PIXEL_COVER_INTERPOLATE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPCI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TPCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tpci_pkg.sv @@
// shared types, constants and helpers of the triangle cover unit
package tpci_pkg;

    localparam int PIXEL_BITS_DEF = 13;
    localparam int VIEW_BITS      = 12;
    localparam int BORDER_BITS    = 10;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 32;
    localparam int QUEUE_DEPTH    = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_W = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_H = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BORD_L = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BORD_T = 4'd7;

    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [31:0]            min_x;
        logic [31:0]            max_x;
        logic [31:0]            min_y;
        logic [31:0]            max_y;
        logic [VIEW_BITS-1:0]   view_w;
        logic [VIEW_BITS-1:0]   view_h;
        logic [BORDER_BITS-1:0] border_l;
        logic [BORDER_BITS-1:0] border_t;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_x:    32'd0,
        max_x:    32'd65536,
        min_y:    32'd0,
        max_y:    32'd65536,
        view_w:   12'd380,
        view_h:   12'd460,
        border_l: 10'd60,
        border_t: 10'd20
    };

    // triangle corners and corner values, all Q16.16
    typedef struct packed {
        logic [31:0] v0_x;
        logic [31:0] v0_y;
        logic [31:0] v1_x;
        logic [31:0] v1_y;
        logic [31:0] v2_x;
        logic [31:0] v2_y;
        logic [31:0] u0;
        logic [31:0] u1;
        logic [31:0] u2;
    } t_tri;

    localparam int TRI_W = $bits(t_tri);

    // exact signed difference of two 32-bit words
    function automatic logic signed [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
        sub33 = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

endpackage

@@ design/tpci_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband word
module tpci_div_pipe #(
    parameter int Q_W = 48,
    parameter int D_W = 12,
    parameter int T_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [Q_W+D_W-1:0] i_num,
    input  logic [D_W-1:0]     i_den,
    input  logic [T_W-1:0]     i_tag,
    output logic               o_valid,
    output logic [Q_W-1:0]     o_quo,
    output logic               o_rem_nz,
    output logic [T_W-1:0]     o_tag
);

    logic           r_vld [0:Q_W];
    logic [D_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0] r_low [0:Q_W];
    logic [D_W-1:0] r_den [0:Q_W];
    logic [T_W-1:0] r_tag [0:Q_W];

    // load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[Q_W+D_W-1:Q_W];
        r_low[0] <= i_num[Q_W-1:0];
        r_den[0] <= i_den;
        r_tag[0] <= i_tag;
    end

    // one shift, compare and subtract per stage
    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [D_W:0] w_try;
        logic [D_W:0] w_diff;
        logic         w_ge;

        assign w_try  = {r_rem[s], r_low[s][Q_W-1]};
        assign w_diff = w_try - {1'b0, r_den[s]};
        assign w_ge   = (w_try >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= w_ge ? w_diff[D_W-1:0] : w_try[D_W-1:0];
            r_low[s+1] <= {r_low[s][Q_W-2:0], w_ge};
            r_den[s+1] <= r_den[s];
            r_tag[s+1] <= r_tag[s];
        end
    end

    assign o_valid  = r_vld[Q_W];
    assign o_quo    = r_low[Q_W];
    assign o_rem_nz = |r_rem[Q_W];
    assign o_tag    = r_tag[Q_W];

endmodule

@@ design/tpci_front.sv @@
// front part: maps the window pixel back to field coordinates
module tpci_front
    import tpci_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_px,
    input  logic [PIXEL_BITS-1:0] i_py,
    input  t_tri                  i_tri,
    output logic                  o_valid,
    output logic [31:0]           o_fx,
    output logic [31:0]           o_fy,
    output logic [PIXEL_BITS-1:0] o_px,
    output logic [PIXEL_BITS-1:0] o_py,
    output t_tri                  o_tri
);

    localparam int DX_W = ((PIXEL_BITS > BORDER_BITS + 1) ? PIXEL_BITS : BORDER_BITS + 1) + 1;
    localparam int DY_W = ((PIXEL_BITS + 1 > VIEW_BITS + 1) ? PIXEL_BITS + 1 : VIEW_BITS + 1) + 2;
    localparam int PX_W = DX_W + 33;
    localparam int PY_W = DY_W + 33;
    localparam int Q_W  = DY_W + 32;
    localparam int N_W  = Q_W + VIEW_BITS;
    localparam int S_W  = Q_W + 2;
    localparam int XT_W = 1 + 2 * PIXEL_BITS + TRI_W;

    logic [VIEW_BITS-1:0] w_w_eff, w_h_eff;
    logic signed [DX_W-1:0] w_dx;
    logic signed [DY_W-1:0] w_dy;

    // zero view size counts as one pixel
    assign w_w_eff = (i_cfg.view_w == '0) ? VIEW_BITS'(1) : i_cfg.view_w;
    assign w_h_eff = (i_cfg.view_h == '0) ? VIEW_BITS'(1) : i_cfg.view_h;

    assign w_dx = $signed({{(DX_W-PIXEL_BITS){i_px[PIXEL_BITS-1]}}, i_px})
                - $signed({{(DX_W-BORDER_BITS){1'b0}}, i_cfg.border_l});
    assign w_dy = $signed({{(DY_W-VIEW_BITS){1'b0}}, w_h_eff})
                - $signed({{(DY_W-PIXEL_BITS){i_py[PIXEL_BITS-1]}}, i_py})
                + $signed({{(DY_W-BORDER_BITS){1'b0}}, i_cfg.border_t});

    // stage 0: pixel offsets and field spans
    logic                   r0_vld;
    logic signed [DX_W-1:0] r0_dx;
    logic signed [DY_W-1:0] r0_dy;
    logic signed [32:0]     r0_spx, r0_spy;
    logic [PIXEL_BITS-1:0]  r0_px, r0_py;
    t_tri                   r0_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_dx  <= w_dx;
        r0_dy  <= w_dy;
        r0_spx <= sub33(i_cfg.max_x, i_cfg.min_x);
        r0_spy <= sub33(i_cfg.max_y, i_cfg.min_y);
        r0_px  <= i_px;
        r0_py  <= i_py;
        r0_tri <= i_tri;
    end

    // stage 1: offset times span
    logic                   r1_vld;
    logic signed [PX_W-1:0] r1_prx;
    logic signed [PY_W-1:0] r1_pry;
    logic [PIXEL_BITS-1:0]  r1_px, r1_py;
    t_tri                   r1_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prx <= r0_dx * r0_spx;
        r1_pry <= r0_dy * r0_spy;
        r1_px  <= r0_px;
        r1_py  <= r0_py;
        r1_tri <= r0_tri;
    end

    // stage 2: sign and magnitude for the dividers
    logic                  r2_vld;
    logic                  r2_negx, r2_negy;
    logic [PX_W-1:0]       r2_magx;
    logic [PY_W-1:0]       r2_magy;
    logic [PIXEL_BITS-1:0] r2_px, r2_py;
    t_tri                  r2_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_negx <= r1_prx[PX_W-1];
        r2_negy <= r1_pry[PY_W-1];
        r2_magx <= r1_prx[PX_W-1] ? -r1_prx : r1_prx;
        r2_magy <= r1_pry[PY_W-1] ? -r1_pry : r1_pry;
        r2_px   <= r1_px;
        r2_py   <= r1_py;
        r2_tri  <= r1_tri;
    end

    // long division by view width and height
    logic                  w_dvx_vld, w_dvy_vld;
    logic [Q_W-1:0]        w_qx, w_qy;
    logic                  w_rzx, w_rzy;
    logic [XT_W-1:0]       w_xtag;
    logic                  w_ytag;
    logic                  w_negx;
    logic [PIXEL_BITS-1:0] w_dpx, w_dpy;
    t_tri                  w_dtri;

    tpci_div_pipe #(.Q_W(Q_W), .D_W(VIEW_BITS), .T_W(XT_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   ({{(N_W-PX_W+1){1'b0}}, r2_magx[PX_W-2:0]}),
        .i_den   (w_w_eff),
        .i_tag   ({r2_negx, r2_px, r2_py, r2_tri}),
        .o_valid (w_dvx_vld),
        .o_quo   (w_qx),
        .o_rem_nz(w_rzx),
        .o_tag   (w_xtag)
    );

    tpci_div_pipe #(.Q_W(Q_W), .D_W(VIEW_BITS), .T_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   ({{(N_W-PY_W+1){1'b0}}, r2_magy[PY_W-2:0]}),
        .i_den   (w_h_eff),
        .i_tag   (r2_negy),
        .o_valid (w_dvy_vld),
        .o_quo   (w_qy),
        .o_rem_nz(w_rzy),
        .o_tag   (w_ytag)
    );

    assign {w_negx, w_dpx, w_dpy, w_dtri} = w_xtag;

    // stage 3: signed floor quotients
    logic                 r3_vld;
    logic [Q_W:0]         r3_qx, r3_qy;
    logic [PIXEL_BITS-1:0] r3_px, r3_py;
    t_tri                 r3_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= w_dvx_vld & w_dvy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_qx  <= w_negx ? (~{1'b0, w_qx} + {{Q_W{1'b0}}, ~w_rzx}) : {1'b0, w_qx};
        r3_qy  <= w_ytag ? (~{1'b0, w_qy} + {{Q_W{1'b0}}, ~w_rzy}) : {1'b0, w_qy};
        r3_px  <= w_dpx;
        r3_py  <= w_dpy;
        r3_tri <= w_dtri;
    end

    // stage 4: add window origin and saturate
    logic [S_W-1:0] w_sx, w_sy;
    logic [31:0]    w_fx, w_fy;

    assign w_sx = {{(S_W-32){i_cfg.min_x[31]}}, i_cfg.min_x} + {r3_qx[Q_W], r3_qx};
    assign w_sy = {{(S_W-32){i_cfg.min_y[31]}}, i_cfg.min_y} + {r3_qy[Q_W], r3_qy};

    always_comb begin
        if (w_sx[S_W-1:31] == '0 || w_sx[S_W-1:31] == '1) begin
            w_fx = w_sx[31:0];
        end else begin
            w_fx = w_sx[S_W-1] ? INT32_MIN : INT32_MAX;
        end
        if (w_sy[S_W-1:31] == '0 || w_sy[S_W-1:31] == '1) begin
            w_fy = w_sy[31:0];
        end else begin
            w_fy = w_sy[S_W-1] ? INT32_MIN : INT32_MAX;
        end
    end

    logic                  r4_vld;
    logic [31:0]           r4_fx, r4_fy;
    logic [PIXEL_BITS-1:0] r4_px, r4_py;
    t_tri                  r4_tri;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_fx  <= w_fx;
        r4_fy  <= w_fy;
        r4_px  <= r3_px;
        r4_py  <= r3_py;
        r4_tri <= r3_tri;
    end

    assign o_valid = r4_vld;
    assign o_fx    = r4_fx;
    assign o_fy    = r4_fy;
    assign o_px    = r4_px;
    assign o_py    = r4_py;
    assign o_tri   = r4_tri;

endmodule

@@ design/tpci_queue.sv @@
// short queue between the front and back parts
module tpci_queue
    import tpci_pkg::*;
#(
    parameter int W     = 64,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic         o_full,
    output logic [W-1:0] o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign w_push = i_push & ~o_full;
    assign w_pop  = i_pop & ~o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];

endmodule

@@ design/tpci_back.sv @@
// back part: barycentric cover test and scalar interpolation
module tpci_back
    import tpci_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [31:0]           i_fx,
    input  logic [31:0]           i_fy,
    input  logic [PIXEL_BITS-1:0] i_px,
    input  logic [PIXEL_BITS-1:0] i_py,
    input  t_tri                  i_tri,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_px,
    output logic [PIXEL_BITS-1:0] o_py,
    output logic                  o_covered,
    output logic                  o_degen,
    output logic [31:0]           o_interp
);

    localparam int CW   = 67;
    localparam int NW   = 101;
    localparam int DQ_W = 33;
    localparam int DD_W = 66;
    localparam int DT_W = 3 + 32 + 2 * PIXEL_BITS;

    // stage 0: edge and offset vectors
    logic                  r0_vld;
    logic signed [32:0]    r0_ax, r0_ay, r0_bx, r0_by, r0_cx, r0_cy, r0_du1, r0_du2;
    logic [31:0]           r0_u0;
    logic [PIXEL_BITS-1:0] r0_px, r0_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_ax  <= sub33(i_tri.v1_x, i_tri.v0_x);
        r0_ay  <= sub33(i_tri.v1_y, i_tri.v0_y);
        r0_bx  <= sub33(i_tri.v2_x, i_tri.v0_x);
        r0_by  <= sub33(i_tri.v2_y, i_tri.v0_y);
        r0_cx  <= sub33(i_fx, i_tri.v0_x);
        r0_cy  <= sub33(i_fy, i_tri.v0_y);
        r0_du1 <= sub33(i_tri.u1, i_tri.u0);
        r0_du2 <= sub33(i_tri.u2, i_tri.u0);
        r0_u0  <= i_tri.u0;
        r0_px  <= i_px;
        r0_py  <= i_py;
    end

    // stage 1: cross product terms
    logic                  r1_vld;
    logic signed [65:0]    r1_p_ab, r1_p_ba, r1_p_ac, r1_p_ca, r1_p_cb, r1_p_bc;
    logic signed [32:0]    r1_du1, r1_du2;
    logic [31:0]           r1_u0;
    logic [PIXEL_BITS-1:0] r1_px, r1_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p_ab <= r0_ax * r0_by;
        r1_p_ba <= r0_ay * r0_bx;
        r1_p_ac <= r0_ax * r0_cy;
        r1_p_ca <= r0_ay * r0_cx;
        r1_p_cb <= r0_cx * r0_by;
        r1_p_bc <= r0_cy * r0_bx;
        r1_du1  <= r0_du1;
        r1_du2  <= r0_du2;
        r1_u0   <= r0_u0;
        r1_px   <= r0_px;
        r1_py   <= r0_py;
    end

    // stage 2: doubled area and the two weights
    logic                  r2_vld;
    logic signed [CW-1:0]  r2_d, r2_sa, r2_sb;
    logic signed [32:0]    r2_du1, r2_du2;
    logic [31:0]           r2_u0;
    logic [PIXEL_BITS-1:0] r2_px, r2_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_d   <= CW'(r1_p_ab) - CW'(r1_p_ba);
        r2_sa  <= CW'(r1_p_ac) - CW'(r1_p_ca);
        r2_sb  <= CW'(r1_p_cb) - CW'(r1_p_bc);
        r2_du1 <= r1_du1;
        r2_du2 <= r1_du2;
        r2_u0  <= r1_u0;
        r2_px  <= r1_px;
        r2_py  <= r1_py;
    end

    // stage 3: make the area positive
    logic                  r3_vld;
    logic                  r3_degen;
    logic signed [CW-1:0]  r3_d, r3_sa, r3_sb;
    logic signed [32:0]    r3_du1, r3_du2;
    logic [31:0]           r3_u0;
    logic [PIXEL_BITS-1:0] r3_px, r3_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_degen <= (r2_d == '0);
        r3_d     <= r2_d[CW-1] ? -r2_d : r2_d;
        r3_sa    <= r2_d[CW-1] ? -r2_sa : r2_sa;
        r3_sb    <= r2_d[CW-1] ? -r2_sb : r2_sb;
        r3_du1   <= r2_du1;
        r3_du2   <= r2_du2;
        r3_u0    <= r2_u0;
        r3_px    <= r2_px;
        r3_py    <= r2_py;
    end

    // stage 4: cover test and partial products of the weighted sum
    logic [CW:0]   w_wsum;
    logic [CW+1:0] w_rest;
    logic          w_cov;

    assign w_wsum = {r3_sa[CW-1], r3_sa} + {r3_sb[CW-1], r3_sb};
    assign w_rest = {{2{r3_d[CW-1]}}, r3_d} - {w_wsum[CW], w_wsum};
    assign w_cov  = ~r3_sa[CW-1] & ~r3_sb[CW-1] & ~w_rest[CW+1] & ~r3_degen;

    logic                  r4_vld;
    logic                  r4_cov, r4_degen;
    logic [DD_W-1:0]       r4_d;
    logic signed [66:0]    r4_pbl, r4_pal;
    logic signed [65:0]    r4_pbh, r4_pah;
    logic [31:0]           r4_u0;
    logic [PIXEL_BITS-1:0] r4_px, r4_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_cov   <= w_cov;
        r4_degen <= r3_degen;
        r4_d     <= r3_d[DD_W-1:0];
        r4_pbl   <= $signed({1'b0, r3_sb[32:0]}) * r3_du1;
        r4_pbh   <= $signed({1'b0, r3_sb[64:33]}) * r3_du1;
        r4_pal   <= $signed({1'b0, r3_sa[32:0]}) * r3_du2;
        r4_pah   <= $signed({1'b0, r3_sa[64:33]}) * r3_du2;
        r4_u0    <= r3_u0;
        r4_px    <= r3_px;
        r4_py    <= r3_py;
    end

    // stage 5: recombine the partial products
    logic                  r5_vld;
    logic                  r5_cov, r5_degen;
    logic [DD_W-1:0]       r5_d;
    logic [NW-2:0]         r5_nb, r5_na;
    logic [31:0]           r5_u0;
    logic [PIXEL_BITS-1:0] r5_px, r5_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_cov   <= r4_cov;
        r5_degen <= r4_degen;
        r5_d     <= r4_d;
        r5_nb    <= ({{(NW-1-66){r4_pbh[65]}}, r4_pbh} << 33)
                  + {{(NW-1-67){r4_pbl[66]}}, r4_pbl};
        r5_na    <= ({{(NW-1-66){r4_pah[65]}}, r4_pah} << 33)
                  + {{(NW-1-67){r4_pal[66]}}, r4_pal};
        r5_u0    <= r4_u0;
        r5_px    <= r4_px;
        r5_py    <= r4_py;
    end

    // stage 6: weighted sum of value differences
    logic                  r6_vld;
    logic                  r6_cov, r6_degen;
    logic [DD_W-1:0]       r6_d;
    logic [NW-1:0]         r6_n;
    logic [31:0]           r6_u0;
    logic [PIXEL_BITS-1:0] r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_cov   <= r5_cov;
        r6_degen <= r5_degen;
        r6_d     <= r5_d;
        r6_n     <= {r5_na[NW-2], r5_na} + {r5_nb[NW-2], r5_nb};
        r6_u0    <= r5_u0;
        r6_px    <= r5_px;
        r6_py    <= r5_py;
    end

    // stage 7: sign and magnitude for the divider
    logic                  r7_vld;
    logic                  r7_cov, r7_degen, r7_neg;
    logic [DD_W-1:0]       r7_d;
    logic [NW-1:0]         r7_mag;
    logic [31:0]           r7_u0;
    logic [PIXEL_BITS-1:0] r7_px, r7_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_cov   <= r6_cov;
        r7_degen <= r6_degen;
        r7_neg   <= r6_n[NW-1];
        r7_mag   <= r6_n[NW-1] ? -r6_n : r6_n;
        r7_d     <= r6_d;
        r7_u0    <= r6_u0;
        r7_px    <= r6_px;
        r7_py    <= r6_py;
    end

    // long division by the doubled area
    logic                  w_dv_vld, w_rz;
    logic [DQ_W-1:0]       w_q;
    logic [DT_W-1:0]       w_tag;
    logic                  w_neg, w_cov_d, w_degen_d;
    logic [31:0]           w_u0;
    logic [PIXEL_BITS-1:0] w_px, w_py;

    tpci_div_pipe #(.Q_W(DQ_W), .D_W(DD_W), .T_W(DT_W)) u_div_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_num   (r7_mag[DQ_W+DD_W-1:0]),
        .i_den   (r7_d),
        .i_tag   ({r7_neg, r7_cov, r7_degen, r7_u0, r7_px, r7_py}),
        .o_valid (w_dv_vld),
        .o_quo   (w_q),
        .o_rem_nz(w_rz),
        .o_tag   (w_tag)
    );

    assign {w_neg, w_cov_d, w_degen_d, w_u0, w_px, w_py} = w_tag;

    // stage 8: signed floor quotient
    logic                  r8_vld;
    logic                  r8_cov, r8_degen;
    logic [DQ_W:0]         r8_q;
    logic [31:0]           r8_u0;
    logic [PIXEL_BITS-1:0] r8_px, r8_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else begin
            r8_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r8_cov   <= w_cov_d;
        r8_degen <= w_degen_d;
        r8_q     <= w_neg ? (~{1'b0, w_q} + {{DQ_W{1'b0}}, ~w_rz}) : {1'b0, w_q};
        r8_u0    <= w_u0;
        r8_px    <= w_px;
        r8_py    <= w_py;
    end

    // stage 9: add base value, saturate, gate by coverage
    logic [DQ_W+1:0] w_sum;
    logic [31:0]     w_val;

    assign w_sum = {{(DQ_W+2-32){r8_u0[31]}}, r8_u0} + {r8_q[DQ_W], r8_q};

    always_comb begin
        if (w_sum[DQ_W+1:31] == '0 || w_sum[DQ_W+1:31] == '1) begin
            w_val = w_sum[31:0];
        end else begin
            w_val = w_sum[DQ_W+1] ? INT32_MIN : INT32_MAX;
        end
    end

    logic                  r9_vld;
    logic                  r9_cov, r9_degen;
    logic [31:0]           r9_val;
    logic [PIXEL_BITS-1:0] r9_px, r9_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r9_cov   <= r8_cov;
        r9_degen <= r8_degen;
        r9_val   <= r8_cov ? w_val : '0;
        r9_px    <= r8_px;
        r9_py    <= r8_py;
    end

    assign o_valid   = r9_vld;
    assign o_px      = r9_px;
    assign o_py      = r9_py;
    assign o_covered = r9_cov;
    assign o_degen   = r9_degen;
    assign o_interp  = r9_val;

endmodule

@@ design/triangle_pixel_cover_interpolate_unit.sv @@
// top level: configuration registers, front part, queue and back part
//
//  channel   direction  handshake                 word
//  command   in         start & !busy             pixel, triangle corners, corner values
//  result    out        o_valid, one cycle        pixel, covered, degenerate, interpolated
//  config    in         i_cfg_we                  i_cfg_idx selects register, i_cfg_data
//
// one word is taken every cycle; a word runs from the accepting edge to the result
// edge through two long-division pipelines of one quotient bit per stage plus a
// load stage (PIXEL_BITS+36 stages for the field mapping, 34 for the interpolation)
// and through the queue register. reset is synchronous and active low; it clears
// all valid flags and loads the register defaults. the queue drains every cycle,
// so busy stays low.
module triangle_pixel_cover_interpolate_unit
    import tpci_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PIXEL_BITS-1:0] i_pixel_x,
    input  logic [PIXEL_BITS-1:0] i_pixel_y,
    input  logic [31:0]           i_vertex0_x,
    input  logic [31:0]           i_vertex0_y,
    input  logic [31:0]           i_vertex1_x,
    input  logic [31:0]           i_vertex1_y,
    input  logic [31:0]           i_vertex2_x,
    input  logic [31:0]           i_vertex2_y,
    input  logic [31:0]           i_value0,
    input  logic [31:0]           i_value1,
    input  logic [31:0]           i_value2,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [PIXEL_BITS-1:0] o_out_pixel_x,
    output logic [PIXEL_BITS-1:0] o_out_pixel_y,
    output logic                  o_covered,
    output logic                  o_degenerate,
    output logic [31:0]           o_interpolated
);

    localparam int QW = 2 * PIXEL_BITS + 64 + TRI_W;

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X:  r_cfg.min_x    <= i_cfg_data;
                CFG_MAX_X:  r_cfg.max_x    <= i_cfg_data;
                CFG_MIN_Y:  r_cfg.min_y    <= i_cfg_data;
                CFG_MAX_Y:  r_cfg.max_y    <= i_cfg_data;
                CFG_VIEW_W: r_cfg.view_w   <= i_cfg_data[VIEW_BITS-1:0];
                CFG_VIEW_H: r_cfg.view_h   <= i_cfg_data[VIEW_BITS-1:0];
                CFG_BORD_L: r_cfg.border_l <= i_cfg_data[BORDER_BITS-1:0];
                CFG_BORD_T: r_cfg.border_t <= i_cfg_data[BORDER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // command word
    logic w_accept;
    t_tri w_tri;

    assign w_accept = start & ~busy;
    assign w_tri = '{
        v0_x: i_vertex0_x, v0_y: i_vertex0_y,
        v1_x: i_vertex1_x, v1_y: i_vertex1_y,
        v2_x: i_vertex2_x, v2_y: i_vertex2_y,
        u0:   i_value0,    u1:   i_value1,   u2: i_value2
    };

    // front part
    logic                  w_f_vld;
    logic [31:0]           w_f_fx, w_f_fy;
    logic [PIXEL_BITS-1:0] w_f_px, w_f_py;
    t_tri                  w_f_tri;

    tpci_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_valid(w_accept),
        .i_px   (i_pixel_x),
        .i_py   (i_pixel_y),
        .i_tri  (w_tri),
        .o_valid(w_f_vld),
        .o_fx   (w_f_fx),
        .o_fy   (w_f_fy),
        .o_px   (w_f_px),
        .o_py   (w_f_py),
        .o_tri  (w_f_tri)
    );

    // queue between the parts
    logic                  w_q_empty, w_q_full;
    logic [QW-1:0]         w_q_head;
    logic [31:0]           w_b_fx, w_b_fy;
    logic [PIXEL_BITS-1:0] w_b_px, w_b_py;
    t_tri                  w_b_tri;

    tpci_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_f_vld),
        .i_data ({w_f_px, w_f_py, w_f_fx, w_f_fy, w_f_tri}),
        .i_pop  (~w_q_empty),
        .o_empty(w_q_empty),
        .o_full (w_q_full),
        .o_head (w_q_head)
    );

    assign {w_b_px, w_b_py, w_b_fx, w_b_fy, w_b_tri} = w_q_head;
    assign busy = w_q_full;

    // back part
    tpci_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (~w_q_empty),
        .i_fx     (w_b_fx),
        .i_fy     (w_b_fy),
        .i_px     (w_b_px),
        .i_py     (w_b_py),
        .i_tri    (w_b_tri),
        .o_valid  (o_valid),
        .o_px     (o_out_pixel_x),
        .o_py     (o_out_pixel_y),
        .o_covered(o_covered),
        .o_degen  (o_degenerate),
        .o_interp (o_interpolated)
    );

endmodule

@@ design/tpci_checker.sv @@
// port-level checker of the triangle cover unit and its bind
`include "triangle_pixel_cover_interpolate_unit_macros.svh"

module tpci_checker #(
    parameter int PIXEL_BITS = 13
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic                  o_covered,
    input logic                  o_degenerate,
    input logic [31:0]           o_interpolated,
    input logic [PIXEL_BITS-1:0] o_out_pixel_x
);

    // a degenerate triangle never covers
    `TPCI_ASSERT_IMPL(a_degen_not_cov, o_valid && o_degenerate, !o_covered, "degenerate word marked covered")

    // uncovered words carry a zero value
    `TPCI_ASSERT_IMPL(a_uncov_zero, o_valid && !o_covered, o_interpolated == 32'd0, "uncovered word has nonzero value")

    // the queue always drains, so commands are never refused
    `TPCI_ASSERT_IMPL(a_never_busy, start, !busy, "command refused")

    // a result word carries no unknown bits
    `TPCI_ASSERT_IMPL(a_known_out, o_valid, !$isunknown({o_out_pixel_x, o_interpolated}), "unknown bits in result word")

    // no word can leave right after reset
    `TPCI_ASSERT_NEXT(a_quiet_after_start, $rose(i_rst_n), !o_valid, "result word too soon after reset")

endmodule

bind triangle_pixel_cover_interpolate_unit tpci_checker #(.PIXEL_BITS(PIXEL_BITS)) u_tpci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_covered     (o_covered),
    .o_degenerate  (o_degenerate),
    .o_interpolated(o_interpolated),
    .o_out_pixel_x (o_out_pixel_x)
);

@@ test/tri_cover_checker.sv @@
// checker for the triangle cover unit: predicts each result word and compares it
module tri_cover_checker
    import tpci_pkg::*;
#(
    parameter int PB = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [PB-1:0]         i_pixel_x,
    input  logic [PB-1:0]         i_pixel_y,
    input  t_tri                  i_tri,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [PB-1:0]         i_out_pixel_x,
    input  logic [PB-1:0]         i_out_pixel_y,
    input  logic                  i_covered,
    input  logic                  i_degenerate,
    input  logic [31:0]           i_interpolated,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct {
        logic [PB-1:0] px;
        logic [PB-1:0] py;
        logic          cov;
        logic          deg;
        logic [31:0]   val;
    } t_cover_word;

    t_cfg        view_cfg;
    t_cover_word expected_words[$];

    // floor division by a positive divisor
    function automatic logic signed [127:0] floor_div(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] q;
        q = n / d;
        if (n < 0 && (n % d) != 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] clamp_q16(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return INT32_MAX;
        if (v < -128'sd2147483648) return INT32_MIN;
        return v[31:0];
    endfunction

    // map the pixel into the field, then run the exact barycentric test
    function automatic t_cover_word predict_cover(input t_cfg c, input logic [PB-1:0] px,
                                                  input logic [PB-1:0] py, input t_tri t);
        logic signed [127:0] w, h, span, tmp, fx, fy;
        logic signed [127:0] ax, ay, bx, by, cx, cy, d, sa, sb, n, q;
        t_cover_word r;
        w = (c.view_w == 0) ? 128'sd1 : 128'(c.view_w);
        h = (c.view_h == 0) ? 128'sd1 : 128'(c.view_h);
        span = $signed(c.max_x) - $signed(c.min_x);
        tmp = $signed(px);
        tmp = (tmp - c.border_l) * span;
        fx = $signed(clamp_q16($signed(c.min_x) + floor_div(tmp, w)));
        span = $signed(c.max_y) - $signed(c.min_y);
        tmp = $signed(py);
        tmp = (h - tmp + c.border_t) * span;
        fy = $signed(clamp_q16($signed(c.min_y) + floor_div(tmp, h)));
        ax = $signed(t.v1_x) - $signed(t.v0_x);
        ay = $signed(t.v1_y) - $signed(t.v0_y);
        bx = $signed(t.v2_x) - $signed(t.v0_x);
        by = $signed(t.v2_y) - $signed(t.v0_y);
        cx = fx - $signed(t.v0_x);
        cy = fy - $signed(t.v0_y);
        d  = ax * by - ay * bx;
        sa = ax * cy - ay * cx;
        sb = cx * by - cy * bx;
        r.px = px;
        r.py = py;
        r.cov = 1'b0;
        r.deg = (d == 0);
        r.val = '0;
        if (d != 0) begin
            if (d < 0) begin
                d = -d;
                sa = -sa;
                sb = -sb;
            end
            if (sa >= 0 && sb >= 0 && d - (sa + sb) >= 0) begin
                n = sb * ($signed(t.u1) - $signed(t.u0)) + sa * ($signed(t.u2) - $signed(t.u0));
                q = floor_div(n, d);
                tmp = $signed(t.u0);
                r.cov = 1'b1;
                r.val = clamp_q16(tmp + q);
            end
        end
        return r;
    endfunction

    assign o_pending = expected_words.size();

    // register copy, accepted words and result comparison
    always @(posedge i_clk) begin
        t_cover_word e;
        if (!i_rst_n) begin
            view_cfg <= CFG_RESET;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_X:  view_cfg.min_x    <= i_cfg_data;
                    CFG_MAX_X:  view_cfg.max_x    <= i_cfg_data;
                    CFG_MIN_Y:  view_cfg.min_y    <= i_cfg_data;
                    CFG_MAX_Y:  view_cfg.max_y    <= i_cfg_data;
                    CFG_VIEW_W: view_cfg.view_w   <= i_cfg_data[VIEW_BITS-1:0];
                    CFG_VIEW_H: view_cfg.view_h   <= i_cfg_data[VIEW_BITS-1:0];
                    CFG_BORD_L: view_cfg.border_l <= i_cfg_data[BORDER_BITS-1:0];
                    CFG_BORD_T: view_cfg.border_t <= i_cfg_data[BORDER_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                expected_words.push_back(predict_cover(view_cfg, i_pixel_x, i_pixel_y, i_tri));
            if (i_valid) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_words.pop_front();
                    if (e.px !== i_out_pixel_x || e.py !== i_out_pixel_y
                            || e.cov !== i_covered || e.deg !== i_degenerate
                            || e.val !== i_interpolated)
                        o_fail_count <= o_fail_count + 1;
                    if (e.px !== i_out_pixel_x)
                        $error("out_pixel_x expected %0d got %0d", e.px, i_out_pixel_x);
                    if (e.py !== i_out_pixel_y)
                        $error("out_pixel_y expected %0d got %0d", e.py, i_out_pixel_y);
                    if (e.cov !== i_covered)
                        $error("covered expected %0b got %0b", e.cov, i_covered);
                    if (e.deg !== i_degenerate)
                        $error("degenerate expected %0b got %0b", e.deg, i_degenerate);
                    if (e.val !== i_interpolated)
                        $error("interpolated expected %h got %h", e.val, i_interpolated);
                end
            end
        end
    end

endmodule

@@ test/tb.sv @@
// testbench top for the triangle cover unit: stimulus, configuration phases, verdict
module tb;
    import tpci_pkg::*;

    localparam int PB = PIXEL_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd13;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [PB-1:0]         i_pixel_x = '0;
    logic [PB-1:0]         i_pixel_y = '0;
    t_tri                  tri_word = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic [PB-1:0]         o_out_pixel_x;
    logic [PB-1:0]         o_out_pixel_y;
    logic                  o_covered;
    logic                  o_degenerate;
    logic [31:0]           o_interpolated;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    burst_left = 0;
    t_cfg                  aim_cfg = CFG_RESET;

    always #4 i_clk = ~i_clk;

    triangle_pixel_cover_interpolate_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .i_vertex0_x(tri_word.v0_x), .i_vertex0_y(tri_word.v0_y),
        .i_vertex1_x(tri_word.v1_x), .i_vertex1_y(tri_word.v1_y),
        .i_vertex2_x(tri_word.v2_x), .i_vertex2_y(tri_word.v2_y),
        .i_value0(tri_word.u0), .i_value1(tri_word.u1), .i_value2(tri_word.u2),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_out_pixel_x(o_out_pixel_x), .o_out_pixel_y(o_out_pixel_y),
        .o_covered(o_covered), .o_degenerate(o_degenerate), .o_interpolated(o_interpolated)
    );

    tri_cover_checker #(.PB(PB)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y), .i_tri(tri_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_out_pixel_x(o_out_pixel_x), .i_out_pixel_y(o_out_pixel_y),
        .i_covered(o_covered), .i_degenerate(o_degenerate),
        .i_interpolated(o_interpolated), .o_fail_count(fail_count), .o_pending(pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // present one word and hold it until the unit takes it
    task automatic send_word(input logic [PB-1:0] px, input logic [PB-1:0] py, input t_tri t);
        start <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        tri_word <= t;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // bursty sender: random gaps between bursts, some bursts with no gap
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // write enable stays high across a run of writes; the caller lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MIN_X:  aim_cfg.min_x = data;
            CFG_MAX_X:  aim_cfg.max_x = data;
            CFG_MIN_Y:  aim_cfg.min_y = data;
            CFG_MAX_Y:  aim_cfg.max_y = data;
            CFG_VIEW_W: aim_cfg.view_w = data[VIEW_BITS-1:0];
            CFG_VIEW_H: aim_cfg.view_h = data[VIEW_BITS-1:0];
            CFG_BORD_L: aim_cfg.border_l = data[BORDER_BITS-1:0];
            CFG_BORD_T: aim_cfg.border_t = data[BORDER_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // one random word: mostly triangles around the pixel's field point
    task automatic random_word();
        logic [PB-1:0] px, py;
        longint fx, fy, w, h, r;
        t_tri t;
        int kind;
        kind = $urandom_range(0, 99);
        w = (aim_cfg.view_w == 0) ? 1 : aim_cfg.view_w;
        h = (aim_cfg.view_h == 0) ? 1 : aim_cfg.view_h;
        px = PB'(aim_cfg.border_l + $urandom_range(0, 32'(w)));
        py = PB'(aim_cfg.border_t + $urandom_range(0, 32'(h)));
        fx = longint'($signed(aim_cfg.min_x)) + (longint'($signed(px)) - aim_cfg.border_l)
             * (longint'($signed(aim_cfg.max_x)) - longint'($signed(aim_cfg.min_x))) / w;
        fy = longint'($signed(aim_cfg.min_y))
             + (h - longint'($signed(py)) + aim_cfg.border_t)
             * (longint'($signed(aim_cfg.max_y)) - longint'($signed(aim_cfg.min_y))) / h;
        r = longint'(1) << $urandom_range(2, 31);
        t.v0_x = 32'(fx - longint'($urandom_range(0, 32'(r))));
        t.v0_y = 32'(fy - longint'($urandom_range(0, 32'(r))));
        t.v1_x = 32'(fx + longint'($urandom_range(0, 32'(r))));
        t.v1_y = 32'(fy - longint'($urandom_range(0, 32'(r))));
        t.v2_x = 32'(fx + longint'($urandom_range(0, 32'(r))) - (r >> 1));
        t.v2_y = 32'(fy + longint'($urandom_range(0, 32'(r))));
        if ($urandom_range(0, 1) == 0) begin
            // swap orientation
            {t.v1_x, t.v2_x} = {t.v2_x, t.v1_x};
            {t.v1_y, t.v2_y} = {t.v2_y, t.v1_y};
        end
        if ($urandom_range(0, 2) == 0) begin
            t.u0 = $urandom;
            t.u1 = $urandom;
            t.u2 = $urandom;
        end else begin
            t.u0 = 32'($signed(12'($urandom)));
            t.u1 = 32'($signed(20'($urandom)));
            t.u2 = 32'($signed(16'($urandom)));
        end
        if (kind >= 70 && kind < 85) begin
            // collinear or repeated corners
            case ($urandom_range(0, 2))
                0: begin t.v2_x = t.v0_x; t.v2_y = t.v0_y; end
                1: begin t.v1_x = t.v0_x; t.v1_y = t.v0_y; end
                default: begin
                    t.v2_x = 2 * t.v1_x - t.v0_x;
                    t.v2_y = 2 * t.v1_y - t.v0_y;
                end
            endcase
        end else if (kind >= 85) begin
            px = PB'($urandom);
            py = PB'($urandom);
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        end
        pace_sender();
        send_word(px, py, t);
    endtask

    initial begin
        t_tri t;
        logic [31:0] span;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset window: field point (0,0) at pixel (60,480)
        t = '{v0_x: 32'd0, v0_y: 32'd0, v1_x: 32'd65536, v1_y: 32'd0,
              v2_x: 32'd0, v2_y: 32'd65536, u0: 32'd100, u1: 32'd200, u2: 32'd300};
        send_word(PB'(60), PB'(480), t);
        send_word(PB'(250), PB'(250), t);
        send_word(PB'(439), PB'(21), t);
        // reversed orientation
        {t.v1_x, t.v2_x} = {t.v2_x, t.v1_x};
        {t.v1_y, t.v2_y} = {t.v2_y, t.v1_y};
        send_word(PB'(100), PB'(400), t);
        // huge triangle with extreme values, saturation
        t = '{v0_x: INT32_MIN, v0_y: INT32_MIN, v1_x: INT32_MAX, v1_y: INT32_MIN,
              v2_x: INT32_MIN, v2_y: INT32_MAX, u0: INT32_MIN, u1: INT32_MAX, u2: INT32_MAX};
        send_word(PB'(60), PB'(480), t);
        t.u0 = INT32_MAX;
        send_word(PB'(200), PB'(300), t);
        t.u1 = INT32_MIN;
        t.u2 = INT32_MIN;
        send_word(PB'(4095), PB'(4095), t);
        send_word(PB'(-4096), PB'(-4096), t);
        send_word(PB'(0), PB'(0), t);
        // degenerate: all corners equal, then collinear
        t = '0;
        send_word(PB'(60), PB'(480), t);
        t.v1_x = 32'd65536;
        t.v2_x = 32'd131072;
        send_word(PB'(60), PB'(480), t);
        // pixel outside the triangle
        t = '{v0_x: 32'd0, v0_y: 32'd0, v1_x: 32'd10, v1_y: 32'd0,
              v2_x: 32'd0, v2_y: 32'd10, u0: 32'd5, u1: 32'd6, u2: 32'd7};
        send_word(PB'(400), PB'(100), t);
        wait_drained();

        // configuration phases, extremes first
        for (int phase = 0; phase < 11; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_MIN_X, INT32_MIN);  write_reg(CFG_MAX_X, INT32_MAX);
                    write_reg(CFG_MIN_Y, INT32_MIN);  write_reg(CFG_MAX_Y, INT32_MAX);
                    write_reg(CFG_VIEW_W, 32'd0);     write_reg(CFG_VIEW_H, 32'd0);
                    write_reg(CFG_BORD_L, 32'd0);     write_reg(CFG_BORD_T, 32'd0);
                end
                1: begin
                    write_reg(CFG_MIN_X, INT32_MAX);  write_reg(CFG_MAX_X, INT32_MIN);
                    write_reg(CFG_MIN_Y, INT32_MAX);  write_reg(CFG_MAX_Y, INT32_MIN);
                    write_reg(CFG_VIEW_W, 32'd4095);  write_reg(CFG_VIEW_H, 32'd4095);
                    write_reg(CFG_BORD_L, 32'd1023);  write_reg(CFG_BORD_T, 32'd1023);
                end
                default: begin
                    span = 32'd1 << $urandom_range(0, 30);
                    write_reg(CFG_MIN_X, $urandom);
                    write_reg(CFG_MAX_X, aim_cfg.min_x + ($urandom % span) - (span >> 3));
                    write_reg(CFG_MIN_Y, $urandom);
                    write_reg(CFG_MAX_Y, aim_cfg.min_y + ($urandom % span) - (span >> 3));
                    write_reg(CFG_VIEW_W, $urandom_range(1, 1 << $urandom_range(1, 12)));
                    write_reg(CFG_VIEW_H, $urandom_range(1, 1 << $urandom_range(1, 12)));
                    write_reg(CFG_BORD_L, $urandom);
                    write_reg(CFG_BORD_T, $urandom);
                end
            endcase
            // writes to an unused index must be ignored
            write_reg(CFG_UNUSED, $urandom);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            repeat (128) random_word();
            wait_drained();
        end

        repeat (150) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ triangle_pixel_cover_interpolate_unit.f @@
+incdir+design
design/tpci_pkg.sv
design/tpci_div_pipe.sv
design/tpci_front.sv
design/tpci_queue.sv
design/tpci_back.sv
design/triangle_pixel_cover_interpolate_unit.sv
design/tpci_checker.sv
test/tri_cover_checker.sv
test/tb.sv
